### rtl/core/c8alu_pkg.sv
`default_nettype none

package c8alu_pkg;

   localparam int unsigned DataWidth = 8;
   localparam int unsigned AddrWidth = 16;
   localparam int unsigned CmdWidth  = 4;

   localparam logic [AddrWidth-1:0] ZeroPageBaseReset = 16'h2000;

   localparam logic [DataWidth-1:0] BcdLowAdjust  = 8'h06;
   localparam logic [DataWidth-1:0] BcdHighAdjust = 8'h60;
   localparam logic [DataWidth-1:0] BcdSubBias    = 8'h66;
   localparam logic [3:0]           BcdDigitMax   = 4'h9;

   typedef enum logic [CmdWidth-1:0] {
      CMD_LSR_M = 4'd0,
      CMD_AND   = 4'd1,
      CMD_ORA   = 4'd2,
      CMD_EOR   = 4'd3,
      CMD_ASL_M = 4'd4,
      CMD_ADC   = 4'd5,
      CMD_SBC   = 4'd6,
      CMD_ROR_M = 4'd7,
      CMD_ROL_M = 4'd8,
      CMD_ROR_A = 4'd9,
      CMD_ROL_A = 4'd10,
      CMD_ASL_A = 4'd11,
      CMD_INC_A = 4'd12,
      CMD_DEC_A = 4'd13,
      CMD_LSR_A = 4'd14
   } cmd_type;

   // Returns {carry, adjusted value}.
   function automatic logic [DataWidth:0] decimal_fix(input logic [DataWidth-1:0] value);
      logic [DataWidth-1:0] fixed;
      logic                 carry;
      fixed = value;
      carry = 1'b0;
      if (fixed[3:0] > BcdDigitMax) begin
         fixed = fixed + BcdLowAdjust;
      end
      if (fixed[7:4] > BcdDigitMax) begin
         fixed = fixed + BcdHighAdjust;
         carry = 1'b1;
      end
      return {carry, fixed};
   endfunction

endpackage

`default_nettype wire

### rtl/core/cpu8_alu_with_flags.sv
// 8-bit ALU with C, V, N and Z flags.
// The start transfer passes through an input register, then one pass of
// ALU logic into the result register, which drives the rsp_valid strobe.
// Throughput: one operation per cycle; busy is never raised.
// Reset (synchronous, active high) drops both valid stages and loads
// zero_page_base with 0x2000. Results cannot be stalled by the receiver.
`default_nettype none

module cpu8_alu_with_flags (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [3:0]  req_cmd,
   input  wire logic [7:0]  req_acc_in,
   input  wire logic [7:0]  req_operand,
   input  wire logic [7:0]  req_zp_byte,
   input  wire logic [15:0] req_operand_address,
   input  wire logic [7:0]  req_x_index,
   input  wire logic        req_carry_in,
   input  wire logic        req_overflow_in,
   input  wire logic        req_decimal_mode,
   input  wire logic        req_t_mode,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data,
   output logic             rsp_valid,
   output logic [7:0]       rsp_acc_out,
   output logic [7:0]       rsp_mem_out,
   output logic             rsp_mem_write,
   output logic [15:0]      rsp_mem_address,
   output logic             rsp_carry_out,
   output logic             rsp_overflow_out,
   output logic             rsp_negative,
   output logic             rsp_zero
);

   logic        zp_base_ff;
   logic [15:0] zp_base_val_ff;

   logic        req_valid_ff;
   logic [3:0]  cmd_ff;
   logic [7:0]  acc_ff;
   logic [7:0]  operand_ff;
   logic [7:0]  zp_byte_ff;
   logic [15:0] address_ff;
   logic [7:0]  x_index_ff;
   logic        carry_ff;
   logic        overflow_ff;
   logic        decimal_ff;
   logic        t_mode_ff;

   logic        rsp_valid_ff;
   logic [7:0]  acc_out_ff;
   logic [7:0]  mem_out_ff;
   logic        mem_write_ff;
   logic [15:0] mem_address_ff;
   logic        carry_out_ff;
   logic        overflow_out_ff;
   logic        negative_ff;
   logic        zero_ff;

   logic [7:0]  acc_in;
   logic [7:0]  mem_out_in;
   logic        mem_write_in;
   logic [15:0] mem_address_in;
   logic        carry_out_in;
   logic        overflow_out_in;
   logic [7:0]  checked;
   logic [7:0]  logic_src;
   logic [7:0]  logic_res;
   logic [8:0]  sum;
   logic [8:0]  diff;
   logic [8:0]  bcd_adc;
   logic [8:0]  bcd_sbc;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         zp_base_ff     <= 1'b0;
         zp_base_val_ff <= c8alu_pkg::ZeroPageBaseReset;
      end else if (csr_write_enable) begin
         zp_base_ff     <= 1'b1;
         zp_base_val_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         cmd_ff      <= req_cmd;
         acc_ff      <= req_acc_in;
         operand_ff  <= req_operand;
         zp_byte_ff  <= req_zp_byte;
         address_ff  <= req_operand_address;
         x_index_ff  <= req_x_index;
         carry_ff    <= req_carry_in;
         overflow_ff <= req_overflow_in;
         decimal_ff  <= req_decimal_mode;
         t_mode_ff   <= req_t_mode;
      end
   end

   assign sum       = {1'b0, acc_ff} + {1'b0, operand_ff} + {8'd0, carry_ff};
   assign diff      = {1'b0, acc_ff} - {1'b0, operand_ff} - {8'd0, !carry_ff};
   assign bcd_adc   = c8alu_pkg::decimal_fix(sum[7:0]);
   assign bcd_sbc   = c8alu_pkg::decimal_fix(diff[7:0] - c8alu_pkg::BcdSubBias);
   assign logic_src = t_mode_ff ? zp_byte_ff : acc_ff;

   always_comb begin
      unique case (c8alu_pkg::cmd_type'(cmd_ff))
         c8alu_pkg::CMD_AND: logic_res = logic_src & operand_ff;
         c8alu_pkg::CMD_ORA: logic_res = logic_src | operand_ff;
         default:            logic_res = logic_src ^ operand_ff;
      endcase
   end

   always_comb begin
      acc_in          = acc_ff;
      checked         = acc_ff;
      mem_out_in      = 8'd0;
      mem_write_in    = 1'b0;
      mem_address_in  = 16'd0;
      carry_out_in    = carry_ff;
      overflow_out_in = overflow_ff;
      unique case (c8alu_pkg::cmd_type'(cmd_ff))
         c8alu_pkg::CMD_LSR_M, c8alu_pkg::CMD_ASL_M,
         c8alu_pkg::CMD_ROR_M, c8alu_pkg::CMD_ROL_M: begin
            unique case (c8alu_pkg::cmd_type'(cmd_ff))
               c8alu_pkg::CMD_LSR_M: begin
                  mem_out_in   = {1'b0, operand_ff[7:1]};
                  carry_out_in = operand_ff[0];
               end
               c8alu_pkg::CMD_ROR_M: begin
                  mem_out_in   = {carry_ff, operand_ff[7:1]};
                  carry_out_in = operand_ff[0];
               end
               c8alu_pkg::CMD_ASL_M: begin
                  mem_out_in   = {operand_ff[6:0], 1'b0};
                  carry_out_in = operand_ff[7];
               end
               default: begin
                  mem_out_in   = {operand_ff[6:0], carry_ff};
                  carry_out_in = operand_ff[7];
               end
            endcase
            checked        = mem_out_in;
            mem_write_in   = 1'b1;
            mem_address_in = address_ff;
         end
         c8alu_pkg::CMD_AND, c8alu_pkg::CMD_ORA, c8alu_pkg::CMD_EOR: begin
            checked = logic_res;
            if (t_mode_ff) begin
               mem_out_in     = logic_res;
               mem_write_in   = 1'b1;
               mem_address_in = zp_base_val_ff + {8'd0, x_index_ff};
            end else begin
               acc_in = logic_res;
            end
         end
         c8alu_pkg::CMD_ADC: begin
            overflow_out_in = (acc_ff[7] ^ sum[7]) & (operand_ff[7] ^ sum[7]);
            if (decimal_ff) begin
               acc_in       = bcd_adc[7:0];
               carry_out_in = bcd_adc[8];
            end else begin
               acc_in       = sum[7:0];
               carry_out_in = sum[8];
            end
            checked = acc_in;
         end
         c8alu_pkg::CMD_SBC: begin
            overflow_out_in = (acc_ff[7] ^ operand_ff[7]) & (acc_ff[7] ^ diff[7]);
            if (decimal_ff) begin
               acc_in       = bcd_sbc[7:0];
               carry_out_in = bcd_sbc[8];
            end else begin
               acc_in       = diff[7:0];
               carry_out_in = !diff[8];
            end
            checked = acc_in;
         end
         c8alu_pkg::CMD_ROR_A: begin
            acc_in       = {carry_ff, acc_ff[7:1]};
            carry_out_in = acc_ff[0];
            checked      = acc_in;
         end
         c8alu_pkg::CMD_ROL_A: begin
            acc_in       = {acc_ff[6:0], carry_ff};
            carry_out_in = acc_ff[7];
            checked      = acc_in;
         end
         c8alu_pkg::CMD_ASL_A: begin
            acc_in       = {acc_ff[6:0], 1'b0};
            carry_out_in = acc_ff[7];
            checked      = acc_in;
         end
         c8alu_pkg::CMD_INC_A: begin
            acc_in  = acc_ff + 8'd1;
            checked = acc_in;
         end
         c8alu_pkg::CMD_DEC_A: begin
            acc_in  = acc_ff - 8'd1;
            checked = acc_in;
         end
         c8alu_pkg::CMD_LSR_A: begin
            acc_in       = {1'b0, acc_ff[7:1]};
            carry_out_in = acc_ff[0];
            checked      = acc_in;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         acc_out_ff      <= acc_in;
         mem_out_ff      <= mem_out_in;
         mem_write_ff    <= mem_write_in;
         mem_address_ff  <= mem_address_in;
         carry_out_ff    <= carry_out_in;
         overflow_out_ff <= overflow_out_in;
         negative_ff     <= checked[7];
         zero_ff         <= (checked == 8'd0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_acc_out      = acc_out_ff;
   assign rsp_mem_out      = mem_out_ff;
   assign rsp_mem_write    = mem_write_ff;
   assign rsp_mem_address  = mem_address_ff;
   assign rsp_carry_out    = carry_out_ff;
   assign rsp_overflow_out = overflow_out_ff;
   assign rsp_negative     = negative_ff;
   assign rsp_zero         = zero_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##2 rsp_valid)
      else $error("result strobe missing two cycles after start");

   a_no_write_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mem_write |-> rsp_mem_address == 16'd0 && rsp_mem_out == 8'd0)
      else $error("write address or data set without a memory write");

   a_write_keeps_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mem_write |-> rsp_acc_out == $past(req_acc_in, 2))
      else $error("accumulator changed by a memory write operation");

   a_zp_base_written: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> zp_base_ff && zp_base_val_ff == $past(csr_write_data))
      else $error("zero page base not loaded");

endmodule

`default_nettype wire
